// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: sizes, types and encodings.
// Used by the channel interfaces, the directory and the top level.
package lkvc_pkg;

  // Number of entries in the store.
  localparam int unsigned Depth    = 16;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned CapW     = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CapReset = 16;

  typedef logic [AddrW-1:0] slot_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_ALLOC,
    ST_WRITE,
    ST_RESP
  } state_e;

  // Directory operations.
  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_EVICT,
    DIR_TOUCH,
    DIR_INSERT
  } dir_op_e;

  // Command from the sequencer to the directory.
  typedef struct packed {
    dir_op_e op;
    slot_t   slot;
    cnt_t    ecap;
  } dir_cmd_t;

  // Status from the directory to the sequencer.
  typedef struct packed {
    logic [Depth-1:0] valid;
    slot_t            free_slot;
  } dir_stat_t;

endpackage

// ===== rtl/lkvc_req_if.sv =====
// Request channel of the LRU key-value cache: command, key and value word.
// Depends on lkvc_pkg for the data width.
interface lkvc_req_if import lkvc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [DataW-1:0] key;
  logic signed [DataW-1:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// ===== rtl/lkvc_rsp_if.sv =====
// Response channel of the LRU key-value cache: hit flag and read value word.
// Depends on lkvc_pkg for the data width.
interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [DataW-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/lkvc_cfg_if.sv =====
// Configuration write channel of the LRU key-value cache: capacity word.
// Depends on lkvc_pkg for the register width.
interface lkvc_cfg_if import lkvc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lru_key_value_cache.sv =====
// LRU key-value cache top level: sequencer, key/value memory and capacity register.
// Depends on lkvc_pkg, the three channel interfaces and lkvc_dir.
// Each request scans the key memory one entry per cycle, read through a registered port;
// a hit ends the scan early. A new request is accepted only in the idle state. The result
// word sits in an output register. Reset clears valid bits, ranks and count at once and
// sets capacity to 16.
module lru_key_value_cache import lkvc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkvc_req_if.sink   req_i,
  lkvc_rsp_if.source rsp_o,
  lkvc_cfg_if.sink   cfg_i
);

  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  state_e                state_q, state_d;
  logic [CapW-1:0]       cap_q;
  logic [CmpW-1:0]       cap_ext;
  cnt_t                  ecap;
  logic                  cmd_q;
  logic [DataW-1:0]      key_q, val_q;
  cnt_t                  scan_cnt_q, scan_cnt_d;
  logic                  cmp_pend_q;
  slot_t                 cmp_idx_q;
  slot_t                 slot_q;
  logic                  ins_q;
  logic                  res_hit_q;
  logic [DataW-1:0]      res_val_q;
  logic                  out_vld_q, out_vld_d;
  logic                  out_hit_q;
  logic [DataW-1:0]      out_val_q;
  logic [2*DataW-1:0]    mem_q [Depth];
  logic [2*DataW-1:0]    rd_data_q;
  logic                  accept;
  logic                  issue;
  logic                  match;
  logic                  scan_done;
  logic                  mem_we;
  logic                  rsp_load;
  dir_cmd_t              dir_cmd;
  dir_stat_t             dir_stat;

  // Capacity register; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(CapReset);
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.data;
    end
  end

  // Effective capacity: zero acts as one, values above the depth as the depth.
  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      ecap = CntW'(1);
    end else if (cap_ext > CmpW'(Depth)) begin
      ecap = CntW'(Depth);
    end else begin
      ecap = CntW'(cap_ext);
    end
  end

  // Request handshake and scan control.
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign match       = cmp_pend_q && dir_stat.valid[cmp_idx_q] &&
                       (rd_data_q[2*DataW-1:DataW] == key_q);
  assign scan_done   = cmp_pend_q && (match || (cmp_idx_q == AddrW'(Depth - 1)));
  assign issue       = (state_q == ST_SCAN) && (scan_cnt_q < CntW'(Depth)) && !match;

  always_comb begin
    scan_cnt_d = scan_cnt_q;
    if (accept) begin
      scan_cnt_d = '0;
    end else if (issue) begin
      scan_cnt_d = scan_cnt_q + 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (!cmd_q) begin
            state_d = ST_RESP;
          end else if (match) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_EVICT;
          end
        end
      end
      ST_EVICT: state_d = ST_ALLOC;
      ST_ALLOC: state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      ST_RESP: begin
        if (!out_vld_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs: directory command, memory write and response load.
  always_comb begin
    dir_cmd.op   = DIR_NONE;
    dir_cmd.slot = slot_q;
    dir_cmd.ecap = ecap;
    mem_we       = 1'b0;
    rsp_load     = 1'b0;
    unique case (state_q)
      ST_EVICT: dir_cmd.op = DIR_EVICT;
      ST_WRITE: begin
        dir_cmd.op = ins_q ? DIR_INSERT : DIR_TOUCH;
        mem_we     = 1'b1;
      end
      ST_RESP:  rsp_load = !out_vld_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign out_vld_d = rsp_load || (out_vld_q && !rsp_o.ready);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      cmp_pend_q <= 1'b0;
      cmp_idx_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_pend_q <= issue;
      cmp_idx_q  <= scan_cnt_q[AddrW-1:0];
      out_vld_q  <= out_vld_d;
    end
  end

  // Request, scan result and response payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.command;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
    if ((state_q == ST_SCAN) && scan_done) begin
      res_hit_q <= match;
      res_val_q <= match ? rd_data_q[DataW-1:0] : '1;
      slot_q    <= cmp_idx_q;
      ins_q     <= !match;
    end else if (state_q == ST_ALLOC) begin
      slot_q <= dir_stat.free_slot;
    end
    if (rsp_load) begin
      out_hit_q <= res_hit_q;
      out_val_q <= res_val_q;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.read_value = out_val_q;

  // Key/value memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= {key_q, val_q};
    end
    rd_data_q <= mem_q[scan_cnt_q[AddrW-1:0]];
  end

  // Valid bits, recency ranks and count.
  lkvc_dir u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dir_cmd),
    .stat_o (dir_stat)
  );

  // A response word appears only out of the response state.
  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_RESP))
    else $error("response raised outside the response state");

  // After eviction a free slot exists for the new key.
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC) |-> !(&dir_stat.valid))
    else $error("no free slot at allocation");

  // An accepted request starts its scan at entry zero.
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == ST_SCAN) && (scan_cnt_q == '0)))
    else $error("scan did not start at entry zero");

  // A finished get carries the scan outcome into the response state.
  a_get_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && scan_done && !cmd_q) |=>
      ((state_q == ST_RESP) && (res_hit_q == $past(match))))
    else $error("get result lost");

endmodule

// ===== rtl/lkvc_dir.sv =====
// Directory of the LRU key-value cache: valid bits, recency ranks and entry count.
// Depends on lkvc_pkg; driven by the sequencer in lru_key_value_cache.
module lkvc_dir import lkvc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dir_cmd_t  cmd_i,
  output dir_stat_t stat_o
);

  logic [Depth-1:0] valid_q, valid_d;
  slot_t            rank_q [Depth];
  slot_t            rank_d [Depth];
  cnt_t             count_q, count_d;
  slot_t            slot_rank;
  slot_t            free_slot;

  // Rank of the entry being touched.
  assign slot_rank = rank_q[cmd_i.slot];

  // Next directory state. Ranks of valid entries always form 0..count-1,
  // so the least recent entries are those with the largest ranks and all
  // evictions that one insertion needs happen at once.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    unique case (cmd_i.op)
      DIR_EVICT: begin
        if (count_q >= cmd_i.ecap) begin
          for (int i = 0; i < Depth; i++) begin
            if (valid_q[i] && (CntW'(rank_q[i]) >= cmd_i.ecap - 1'b1)) begin
              valid_d[i] = 1'b0;
              rank_d[i]  = '0;
            end
          end
          count_d = cmd_i.ecap - 1'b1;
        end
      end
      DIR_TOUCH, DIR_INSERT: begin
        for (int i = 0; i < Depth; i++) begin
          if (valid_q[i] && (AddrW'(i) != cmd_i.slot) &&
              ((cmd_i.op == DIR_INSERT) || (rank_q[i] < slot_rank))) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[cmd_i.slot] = '0;
        if (cmd_i.op == DIR_INSERT) begin
          valid_d[cmd_i.slot] = 1'b1;
          count_d             = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Lowest-numbered free slot.
  always_comb begin
    free_slot = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AddrW'(i);
      end
    end
  end

  assign stat_o.valid     = valid_q;
  assign stat_o.free_slot = free_slot;

  // Directory registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < Depth; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  // The count tracks the number of valid entries.
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == count_q)
    else $error("entry count differs from number of valid entries");

  // An insertion always lands in a free slot.
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DIR_INSERT) |-> !valid_q[cmd_i.slot])
    else $error("insertion into an occupied slot");

  // A touch always targets a present entry.
  a_touch_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DIR_TOUCH) |-> valid_q[cmd_i.slot])
    else $error("touch of an invalid slot");

  // After eviction there is room for one more entry.
  a_evict_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DIR_EVICT) |=> (count_q < $past(cmd_i.ecap)))
    else $error("eviction left no room");

endmodule
